// File: sv/slrq_pkg.sv
package slrq_pkg;

    localparam logic [2:0] MODE_WR_ACQ  = 3'd0;
    localparam logic [2:0] MODE_PUBLISH = 3'd1;
    localparam logic [2:0] MODE_CANCEL  = 3'd2;
    localparam logic [2:0] MODE_RD_ACQ  = 3'd3;
    localparam logic [2:0] MODE_RD_REL  = 3'd4;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_INVAL   = 3'd1;
    localparam logic [2:0] STAT_STATE   = 3'd2;
    localparam logic [2:0] STAT_BACKP   = 3'd3;
    localparam logic [2:0] STAT_LIMIT   = 3'd4;
    localparam logic [2:0] STAT_UNAVAIL = 3'd5;

    localparam logic [1:0] CFG_STORAGE_BASE    = 2'd0;
    localparam logic [1:0] CFG_SLOT_BYTES      = 2'd1;
    localparam logic [1:0] CFG_SLOT_COUNT_LOG2 = 2'd2;

    localparam logic [31:0] RST_STORAGE_BASE    = 32'd0;
    localparam logic [15:0] RST_SLOT_BYTES      = 16'd64;
    localparam logic [2:0]  RST_SLOT_COUNT_LOG2 = 3'd4;

    typedef struct packed {
        logic [2:0]  mode;
        logic [4:0]  reserve_slots;
        logic [15:0] publish_length;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot_index;
        logic [31:0] slot_address;
        logic [15:0] byte_count;
        logic [4:0]  occupancy;
        logic [31:0] published_count;
        logic [31:0] consumed_count;
        logic [31:0] backpressure_count;
        logic [4:0]  high_water;
    } t_out_word;

    typedef struct packed {
        logic [31:0] storage_base;
        logic [15:0] slot_bytes;
        logic [2:0]  slot_count_log2;
    } t_cfg;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

// File: sv/slot_ring_queue_controller.sv
// Slot ring queue controller: single-producer single-consumer message ring over
// fixed-size slots. Each input word is one operation (write acquire, publish,
// cancel, read acquire, read release) and yields exactly one result word with
// status, slot index and address, byte count, occupancy and the saturating
// counters. S_IDLE takes a word while the slot length memory is read (a
// registered read); S_EXEC updates state and loads the output register, held
// while an untaken result fills it. A new word is taken only in S_IDLE, while
// the last result may still wait there. Slot lengths clear to zero at reset
// through per-entry valid bits, with no clearing pass. Configuration writes are
// always ready and take effect at once; write them only while idle.
module slot_ring_queue_controller #(
    parameter int SLOTS       = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  slrq_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output slrq_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    localparam int CAP_LOG2 = $clog2(SLOTS + 1) - 1;
    localparam int DEPTH    = 1 << CAP_LOG2;
    localparam int AW       = (CAP_LOG2 > 0) ? CAP_LOG2 : 1;

    slrq_pkg::t_state    r_state, n_state;
    slrq_pkg::t_in_word  r_item;
    slrq_pkg::t_cfg      r_cfg;
    slrq_pkg::t_out_word r_out_word, result;
    logic                r_out_valid;
    logic                commit;

    logic [AW-1:0]          rd_addr, wr_addr;
    logic                   wr_en;
    logic [LENGTH_BITS-1:0] wr_data, rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slrq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        commit     = 1'b0;
        unique case (r_state)
            slrq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = slrq_pkg::S_EXEC;
                end
            end
            slrq_pkg::S_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    commit  = 1'b1;
                    n_state = slrq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = slrq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in_word;
        end
        if (commit) begin
            r_out_word <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.storage_base    <= slrq_pkg::RST_STORAGE_BASE;
            r_cfg.slot_bytes      <= slrq_pkg::RST_SLOT_BYTES;
            r_cfg.slot_count_log2 <= slrq_pkg::RST_SLOT_COUNT_LOG2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                slrq_pkg::CFG_STORAGE_BASE:    r_cfg.storage_base    <= i_cfg_data;
                slrq_pkg::CFG_SLOT_BYTES:      r_cfg.slot_bytes      <= i_cfg_data[15:0];
                slrq_pkg::CFG_SLOT_COUNT_LOG2: r_cfg.slot_count_log2 <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    slrq_core #(
        .SLOTS       (SLOTS),
        .LENGTH_BITS (LENGTH_BITS),
        .AW          (AW)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_commit  (commit),
        .i_item    (r_item),
        .i_cfg     (r_cfg),
        .i_len     (rd_data),
        .o_rd_addr (rd_addr),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_result  (result)
    );

    slrq_len_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (LENGTH_BITS)
    ) u_len_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en && commit),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    a_exec_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slrq_pkg::S_EXEC && (!r_out_valid || i_out_ready))
        |=> (o_out_valid && r_state == slrq_pkg::S_IDLE))
        else $error("operation did not complete into the output register");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_word.occupancy) <= DEPTH))
        else $error("occupancy exceeds slot capacity");

    a_peak_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.high_water >= o_out_word.occupancy))
        else $error("high-water mark below occupancy");

endmodule

// File: sv/slrq_len_mem.sv
module slrq_len_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [DW-1:0]    r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// File: sv/slrq_core.sv
module slrq_core #(
    parameter int SLOTS       = 16,
    parameter int LENGTH_BITS = 16,
    parameter int AW          = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_commit,
    input  slrq_pkg::t_in_word     i_item,
    input  slrq_pkg::t_cfg         i_cfg,
    input  logic [LENGTH_BITS-1:0] i_len,
    output logic [AW-1:0]          o_rd_addr,
    output logic                   o_wr_en,
    output logic [AW-1:0]          o_wr_addr,
    output logic [LENGTH_BITS-1:0] o_wr_data,
    output slrq_pkg::t_out_word    o_result
);

    localparam int CAP_LOG2 = $clog2(SLOTS + 1) - 1;
    localparam int SEQ_W    = CAP_LOG2 + 1;
    localparam int CMP_W    = (CAP_LOG2 + 2 > 5) ? CAP_LOG2 + 2 : 5;

    logic [SEQ_W-1:0] r_prod, r_cons, r_peak;
    logic             r_wheld, r_rheld;
    logic [AW-1:0]    r_wslot;
    logic [31:0]      r_pub, r_con, r_ref;

    logic [SEQ_W-1:0] n_prod, n_cons, n_peak;
    logic             n_wheld, n_rheld;
    logic [AW-1:0]    n_wslot;
    logic [31:0]      n_pub, n_con, n_ref;

    logic [3:0]       lg_eff;
    logic [CMP_W-1:0] count, res, occ_ext;
    logic [SEQ_W-1:0] cm1, occ, occ_new, occ_out;
    logic [AW-1:0]    wr_idx, rd_idx, sel_idx;
    logic [AW+15:0]   prod;
    logic [2:0]       status;
    logic             grant;
    logic [15:0]      bytes;

    always_comb begin
        lg_eff  = ({1'b0, i_cfg.slot_count_log2} > 4'(CAP_LOG2))
                  ? 4'(CAP_LOG2) : {1'b0, i_cfg.slot_count_log2};
        count   = CMP_W'(1) << lg_eff;
        cm1     = SEQ_W'(count - CMP_W'(1));
        wr_idx  = AW'(r_prod & cm1);
        rd_idx  = AW'(r_cons & cm1);
        occ     = r_prod - r_cons;
        occ_ext = CMP_W'(occ);
        res     = CMP_W'(i_item.reserve_slots);

        n_prod  = r_prod;
        n_cons  = r_cons;
        n_peak  = r_peak;
        n_wheld = r_wheld;
        n_rheld = r_rheld;
        n_wslot = r_wslot;
        n_pub   = r_pub;
        n_con   = r_con;
        n_ref   = r_ref;
        occ_new = occ + SEQ_W'(1);

        status    = slrq_pkg::STAT_OK;
        grant     = 1'b0;
        sel_idx   = wr_idx;
        bytes     = '0;
        o_wr_en   = 1'b0;
        o_wr_data = LENGTH_BITS'(i_item.publish_length);

        unique case (i_item.mode)
            slrq_pkg::MODE_WR_ACQ: begin
                priority if (res >= count) begin
                    status = slrq_pkg::STAT_INVAL;
                end else if (r_wheld) begin
                    status = slrq_pkg::STAT_STATE;
                end else if (occ_ext >= count - res) begin
                    status = slrq_pkg::STAT_BACKP;
                    n_ref  = (r_ref == '1) ? r_ref : r_ref + 32'd1;
                end else begin
                    grant   = 1'b1;
                    n_wslot = wr_idx;
                    n_wheld = 1'b1;
                    bytes   = i_cfg.slot_bytes;
                end
            end
            slrq_pkg::MODE_PUBLISH: begin
                priority if (!r_wheld) begin
                    status = slrq_pkg::STAT_STATE;
                end else if (i_item.publish_length > i_cfg.slot_bytes) begin
                    status = slrq_pkg::STAT_LIMIT;
                end else begin
                    o_wr_en = 1'b1;
                    n_prod  = r_prod + SEQ_W'(1);
                    n_wheld = 1'b0;
                    n_pub   = (r_pub == '1) ? r_pub : r_pub + 32'd1;
                    if (occ_new > r_peak) begin
                        n_peak = occ_new;
                    end
                end
            end
            slrq_pkg::MODE_CANCEL: begin
                if (!r_wheld) begin
                    status = slrq_pkg::STAT_STATE;
                end else begin
                    n_wheld = 1'b0;
                end
            end
            slrq_pkg::MODE_RD_ACQ: begin
                priority if (r_rheld) begin
                    status = slrq_pkg::STAT_STATE;
                end else if (r_cons == r_prod) begin
                    status = slrq_pkg::STAT_UNAVAIL;
                end else begin
                    grant   = 1'b1;
                    sel_idx = rd_idx;
                    n_rheld = 1'b1;
                    bytes   = 16'(i_len);
                end
            end
            slrq_pkg::MODE_RD_REL: begin
                if (!r_rheld) begin
                    status = slrq_pkg::STAT_STATE;
                end else begin
                    n_rheld = 1'b0;
                    n_cons  = r_cons + SEQ_W'(1);
                    n_con   = (r_con == '1) ? r_con : r_con + 32'd1;
                end
            end
            default: begin
                status = slrq_pkg::STAT_INVAL;
            end
        endcase

        prod    = (AW+16)'(sel_idx) * (AW+16)'(i_cfg.slot_bytes);
        occ_out = n_prod - n_cons;

        o_result.status             = status;
        o_result.slot_index         = grant ? 4'(sel_idx) : 4'd0;
        o_result.slot_address       = grant ? i_cfg.storage_base + 32'(prod) : 32'd0;
        o_result.byte_count         = bytes;
        o_result.occupancy          = 5'(occ_out);
        o_result.published_count    = n_pub;
        o_result.consumed_count     = n_con;
        o_result.backpressure_count = n_ref;
        o_result.high_water         = 5'(n_peak);
    end

    assign o_rd_addr = rd_idx;
    assign o_wr_addr = r_wslot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod  <= '0;
            r_cons  <= '0;
            r_peak  <= '0;
            r_wheld <= 1'b0;
            r_rheld <= 1'b0;
            r_wslot <= '0;
            r_pub   <= '0;
            r_con   <= '0;
            r_ref   <= '0;
        end else if (i_commit) begin
            r_prod  <= n_prod;
            r_cons  <= n_cons;
            r_peak  <= n_peak;
            r_wheld <= n_wheld;
            r_rheld <= n_rheld;
            r_wslot <= n_wslot;
            r_pub   <= n_pub;
            r_con   <= n_con;
            r_ref   <= n_ref;
        end
    end

endmodule
